>>> rtl/mssd_pkg.sv
// Shared types and constants of the multiplexed seven-segment driver.
// Used by the register block, controller, datapath and top level.
package mssd_pkg;

   // Number of digits on the display (1 to 4)
   localparam int DIGITS = 4;
   localparam int WORD_W = 8 * DIGITS;
   localparam int DIGIT_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // Enable pins and scan counter widths are fixed by the pin-out
   localparam int EN_W = 4;
   localparam int SCAN_W = 5;

   // Reciprocal of ten for a 15-bit dividend: q = (v * QUOT_MUL) >> QUOT_SHIFT
   localparam logic [15:0] QUOT_MUL = 16'd52429;
   localparam int QUOT_SHIFT = 19;

   // Register file geometry
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   typedef enum logic [2:0] {
      REG_PAT_LO     = 3'd0,
      REG_PAT_HI     = 3'd1,
      REG_WIRING     = 3'd2,
      REG_INVERT     = 3'd3,
      REG_BRIGHTNESS = 3'd4
   } reg_index_type;

   localparam logic [23:0] WIRING_RESET = 24'hFAC688;
   localparam logic [3:0] BRIGHTNESS_RESET = 4'hF;

   typedef enum logic [1:0] {
      KIND_SET   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [63:0] pat_lo;
      logic [15:0] pat_hi;
      logic [23:0] wiring;
      logic        invert;
      logic [3:0]  brightness;
   } cfg_type;

   typedef struct packed {
      logic start_set;
      logic step_digit;
      logic clear_word;
      logic advance_scan;
      logic load_bit;
      logic load_end;
   } cmd_type;

   typedef struct packed {
      logic conv_stop;
      logic scan_digit;
      logic bits_done;
   } status_type;

endpackage

>>> rtl/mssd_csr.sv
// Configuration registers of the seven-segment driver behind an APB-style port.
// Depends on mssd_pkg for the register map and the configuration struct.
module mssd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mssd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mssd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mssd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output mssd_pkg::cfg_type               cfg
);
   import mssd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [2:0] reg_sel;
   logic write_en;

   assign csr_pready = 1'b1;
   assign reg_sel = csr_paddr[5:3];
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg = cfg_ff;

   // Decode the write word into the selected register
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_PAT_LO:     cfg_in.pat_lo = csr_pwdata;
            REG_PAT_HI:     cfg_in.pat_hi = csr_pwdata[15:0];
            REG_WIRING:     cfg_in.wiring = csr_pwdata[23:0];
            REG_INVERT:     cfg_in.invert = csr_pwdata[0];
            REG_BRIGHTNESS: cfg_in.brightness = csr_pwdata[3:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pat_lo <= '0;
         cfg_ff.pat_hi <= '0;
         cfg_ff.wiring <= WIRING_RESET;
         cfg_ff.invert <= 1'b0;
         cfg_ff.brightness <= BRIGHTNESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the selected register
   always_comb begin
      unique case (reg_sel)
         REG_PAT_LO:     csr_prdata = cfg_ff.pat_lo;
         REG_PAT_HI:     csr_prdata = {48'd0, cfg_ff.pat_hi};
         REG_WIRING:     csr_prdata = {40'd0, cfg_ff.wiring};
         REG_INVERT:     csr_prdata = {63'd0, cfg_ff.invert};
         REG_BRIGHTNESS: csr_prdata = {60'd0, cfg_ff.brightness};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

>>> rtl/mssd_datapath.sv
// Datapath of the seven-segment driver: digit conversion, display word,
// scan counter and the result word register. Depends on mssd_pkg.
module mssd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mssd_pkg::cfg_type    cfg,
   input  mssd_pkg::cmd_type    cmd,
   output mssd_pkg::status_type status,
   input  logic [14:0]          req_number_value,
   input  logic [1:0]           req_min_digits,
   input  logic [2:0]           req_point_position,
   output logic                 rsp_bit_valid,
   output logic                 rsp_serial_bit,
   output logic [3:0]           rsp_digit_enables,
   output logic                 rsp_last
);
   import mssd_pkg::*;

   // Move raw segment bit b to the bit position its wiring field names
   function automatic logic [7:0] rewire(input logic [7:0] raw, input logic [23:0] map);
      logic [7:0] res;
      res = '0;
      for (int b = 0; b < 8; b++) begin
         if (raw[b]) begin
            res[map[3*b +: 3]] = 1'b1;
         end
      end
      return res;
   endfunction

   logic [WORD_W-1:0]      word_ff, word_in;
   logic [SCAN_W-1:0]      scan_ff, scan_in;
   logic [14:0]            value_ff, value_in;
   logic [1:0]             min_ff, min_in;
   logic [DIGIT_IDX_W-1:0] digit_ff, digit_in;
   logic [3:0]             bitcnt_ff, bitcnt_in;
   logic                   bit_valid_ff, bit_valid_in;
   logic                   serial_ff, serial_in;
   logic [EN_W-1:0]        en_ff, en_in;
   logic                   last_ff, last_in;

   logic [30:0]       prod;
   logic [11:0]       quot;
   logic [14:0]       tens;
   logic [3:0]        rem;
   logic [7:0]        pattern;
   logic [7:0]        seg_byte;
   logic [WORD_W-1:0] point_mask;
   logic [5:0]        scan_limit;
   logic [7:0]        cur_byte;
   logic [EN_W-1:0]   idle_en;
   logic [EN_W-1:0]   slot_en;

   // Divide the remaining value by ten and find the ones digit
   assign prod = 31'(value_ff) * 31'(QUOT_MUL);
   assign quot = prod[30:QUOT_SHIFT];
   assign tens = 15'({quot, 3'b000}) + 15'({quot, 1'b0});
   assign rem = 4'(value_ff - tens);

   // Look the digit up in the pattern table
   always_comb begin
      unique case (rem)
         4'd0:    pattern = cfg.pat_lo[7:0];
         4'd1:    pattern = cfg.pat_lo[15:8];
         4'd2:    pattern = cfg.pat_lo[23:16];
         4'd3:    pattern = cfg.pat_lo[31:24];
         4'd4:    pattern = cfg.pat_lo[39:32];
         4'd5:    pattern = cfg.pat_lo[47:40];
         4'd6:    pattern = cfg.pat_lo[55:48];
         4'd7:    pattern = cfg.pat_lo[63:56];
         4'd8:    pattern = cfg.pat_hi[7:0];
         4'd9:    pattern = cfg.pat_hi[15:8];
         default: pattern = '0;
      endcase
   end

   assign seg_byte = rewire(pattern, cfg.wiring);

   // Stop after the last display digit, or once the rest is zero past the minimum
   assign status.conv_stop = (quot == '0 && 32'(min_ff) <= 32'(digit_ff))
                          || (32'(digit_ff) == DIGITS - 1);

   // Decimal point bit of the requested digit
   always_comb begin
      point_mask = '0;
      for (int d = 0; d < DIGITS; d++) begin
         point_mask[8*d + 3] = (req_point_position == 3'(d + 1));
      end
   end

   // Scan slot bookkeeping
   assign scan_limit = 6'(DIGITS - 1) + {2'b00, ~cfg.brightness};
   assign status.scan_digit = (32'(scan_ff) < DIGITS);
   assign status.bits_done = bitcnt_ff[3];

   always_comb begin
      cur_byte = '0;
      slot_en = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (32'(scan_ff) == d) begin
            cur_byte = word_ff[8*d +: 8];
            slot_en[d] = 1'b1;
         end
      end
   end

   assign idle_en = {EN_W{cfg.invert}};

   // Next state of the datapath registers
   always_comb begin
      word_in = word_ff;
      scan_in = scan_ff;
      value_in = value_ff;
      min_in = min_ff;
      digit_in = digit_ff;
      bitcnt_in = bitcnt_ff;
      bit_valid_in = bit_valid_ff;
      serial_in = serial_ff;
      en_in = en_ff;
      last_in = last_ff;

      if (cmd.start_set) begin
         word_in = point_mask;
         value_in = req_number_value;
         min_in = req_min_digits;
         digit_in = '0;
      end
      if (cmd.step_digit) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (32'(digit_ff) == d) begin
               word_in[8*d +: 8] = word_ff[8*d +: 8] | seg_byte;
            end
         end
         value_in = 15'(quot);
         digit_in = digit_ff + 1'b1;
      end
      if (cmd.clear_word) begin
         word_in = '0;
      end
      if (cmd.advance_scan) begin
         scan_in = ({1'b0, scan_ff} > scan_limit) ? '0 : scan_ff + 1'b1;
         bitcnt_in = '0;
      end
      if (cmd.load_bit) begin
         bit_valid_in = 1'b1;
         serial_in = cur_byte[bitcnt_ff[2:0]] ^ cfg.invert;
         en_in = idle_en;
         last_in = 1'b0;
         bitcnt_in = bitcnt_ff + 1'b1;
      end
      if (cmd.load_end) begin
         bit_valid_in = 1'b0;
         serial_in = 1'b0;
         en_in = idle_en ^ (status.scan_digit ? slot_en : '0);
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         scan_ff <= '0;
      end else begin
         word_ff <= word_in;
         scan_ff <= scan_in;
      end
      value_ff <= value_in;
      min_ff <= min_in;
      digit_ff <= digit_in;
      bitcnt_ff <= bitcnt_in;
      bit_valid_ff <= bit_valid_in;
      serial_ff <= serial_in;
      en_ff <= en_in;
      last_ff <= last_in;
   end

   assign rsp_bit_valid = bit_valid_ff;
   assign rsp_serial_bit = serial_ff;
   assign rsp_digit_enables = en_ff;
   assign rsp_last = last_ff;

endmodule

>>> rtl/mssd_ctrl.sv
// Controller of the seven-segment driver: sequences conversion and scan output
// and owns the handshakes. Depends on mssd_pkg for command and status structs.
module mssd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mssd_pkg::status_type status,
   output mssd_pkg::cmd_type    cmd
);
   import mssd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            // Take a word and dispatch on its kind
            if (req_valid) begin
               unique case (req_kind)
                  KIND_SET: begin
                     cmd.start_set = 1'b1;
                     state_in = ST_CONVERT;
                  end
                  KIND_CLEAR: begin
                     cmd.clear_word = 1'b1;
                  end
                  KIND_TICK: begin
                     cmd.advance_scan = 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            // One decimal digit per cycle
            cmd.step_digit = 1'b1;
            if (status.conv_stop) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // Load the next result word once the output register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (status.scan_digit && !status.bits_done) begin
                  cmd.load_bit = 1'b1;
               end else begin
                  cmd.load_end = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/multiplexed_seven_segment_driver.sv
// Multiplexed seven-segment display driver, top level.
// Instantiates mssd_csr, mssd_ctrl and mssd_datapath; depends on mssd_pkg.
//
// Input channel (req_*): one word per item. Kind set converts number_value
// into up to four decimal digits, one digit per cycle, and stores their
// rewired segment patterns plus an optional decimal point. Kind clear
// blanks the display. Kind tick advances the scan counter, which also
// walks through 16 - brightness dimming slots.
// Output channel (rsp_*): a tick in a digit slot yields nine words, eight
// serial data bits least significant first and then one word that enables
// the digit with last set; a tick in a dimming slot yields one last word.
// With the receiver always ready, a digit tick first advances the scan and
// then one result word per cycle leaves the output register.
// A stalled receiver holds the output register and the controller waits;
// no new item is taken until the current one has loaded its last word.
// Configuration registers sit on the csr_* port at byte address 8 * index.
// Reset clears the display word and scan counter and restores register
// defaults (identity wiring, full brightness, no inversion).
module multiplexed_seven_segment_driver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [14:0]                     req_number_value,
   input  logic [1:0]                      req_min_digits,
   input  logic [2:0]                      req_point_position,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_bit_valid,
   output logic                            rsp_serial_bit,
   output logic [3:0]                      rsp_digit_enables,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mssd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mssd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mssd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import mssd_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   mssd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mssd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_number_value   (req_number_value),
      .req_min_digits     (req_min_digits),
      .req_point_position (req_point_position),
      .rsp_bit_valid      (rsp_bit_valid),
      .rsp_serial_bit     (rsp_serial_bit),
      .rsp_digit_enables  (rsp_digit_enables),
      .rsp_last           (rsp_last)
   );

endmodule

>>> test/multiplexed_seven_segment_driver_test.sv
// Self-checking bench for multiplexed_seven_segment_driver: random and directed
// words on req_*, checked word by word on rsp_* against a scoreboard model.
// Depends on mssd_pkg and the driver RTL.
`timescale 1ns / 1ps

module multiplexed_seven_segment_driver_test;
   import mssd_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT = 20000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 32;

   typedef struct packed {
      logic       bit_valid;
      logic       serial_bit;
      logic [3:0] digit_enables;
      logic       last;
   } scan_word_type;

   // Scoreboard: mirror of the registers and display state, queue of words due
   class segment_scoreboard;
      logic [63:0]   pat_lo;
      logic [15:0]   pat_hi;
      logic [23:0]   wiring;
      logic          invert;
      logic [3:0]    brightness;
      logic [31:0]   segments;
      logic [4:0]    scan;
      scan_word_type due_words[$];
      int            errors;

      function new();
         pat_lo = '0;
         pat_hi = '0;
         wiring = WIRING_RESET;
         invert = 1'b0;
         brightness = BRIGHTNESS_RESET;
         segments = '0;
         scan = '0;
         errors = 0;
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function void write_reg(reg_index_type idx, logic [63:0] value);
         case (idx)
            REG_PAT_LO: begin
               pat_lo = value;
            end
            REG_PAT_HI: begin
               pat_hi = value[15:0];
            end
            REG_WIRING: begin
               wiring = value[23:0];
            end
            REG_INVERT: begin
               invert = value[0];
            end
            REG_BRIGHTNESS: begin
               brightness = value[3:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Update the display state and queue the words one accepted item causes
      function void predict_item(logic [1:0] kind, logic [14:0] value,
                                 logic [1:0] min_digits, logic [2:0] point);
         int            v;
         int            i;
         int            b;
         int            pos;
         int            d;
         int            dimm;
         logic [31:0]   raw;
         logic [3:0]    idle;
         bit            done;
         scan_word_type w;
         case (kind)
            KIND_SET: begin
               // Convert ones first; stop once the value is used up past min_digits
               v = int'(value);
               raw = '0;
               done = 1'b0;
               for (i = 0; i < DIGITS; i++) begin
                  if (!done) begin
                     d = v % 10;
                     raw[i*8 +: 8] = (d < 8) ? pat_lo[d*8 +: 8] : pat_hi[(d-8)*8 +: 8];
                     v = v / 10;
                     if (v == 0 && int'(min_digits) <= i) done = 1'b1;
                  end
               end
               // Route each raw bit to its wired position within its byte
               segments = '0;
               for (b = 0; b < 32; b++) begin
                  if (raw[b]) begin
                     pos = (b & 'hF8) + int'(wiring[(b % 8)*3 +: 3]);
                     segments[pos] = 1'b1;
                  end
               end
               if (int'(point) >= 1 && int'(point) <= DIGITS)
                  segments[(int'(point) - 1)*8 + 3] = 1'b1;
            end
            KIND_CLEAR: begin
               segments = '0;
            end
            KIND_TICK: begin
               dimm = 15 - int'(brightness);
               if (int'(scan) > DIGITS - 1 + dimm) scan = '0;
               else scan = scan + 5'd1;
               idle = invert ? 4'hF : 4'h0;
               if (int'(scan) < DIGITS) begin
                  for (i = 0; i < 8; i++) begin
                     w.bit_valid = 1'b1;
                     w.serial_bit = segments[int'(scan)*8 + i] ^ invert;
                     w.digit_enables = idle;
                     w.last = 1'b0;
                     due_words.push_back(w);
                  end
                  w.digit_enables = idle ^ (4'b0001 << scan);
               end else begin
                  w.digit_enables = idle;
               end
               w.bit_valid = 1'b0;
               w.serial_bit = 1'b0;
               w.last = 1'b1;
               due_words.push_back(w);
            end
            default: begin
            end
         endcase
      endfunction

      // Compare one received word with the oldest word due
      function void check_word(scan_word_type got);
         scan_word_type want;
         if (due_words.size() == 0) begin
            report($sformatf("word with nothing due: valid %0d bit %0d en %h last %0d",
                             got.bit_valid, got.serial_bit, got.digit_enables, got.last));
            return;
         end
         want = due_words.pop_front();
         if (got.bit_valid !== want.bit_valid)
            report($sformatf("bit_valid %0d, want %0d", got.bit_valid, want.bit_valid));
         if (got.serial_bit !== want.serial_bit)
            report($sformatf("serial_bit %0d, want %0d", got.serial_bit, want.serial_bit));
         if (got.digit_enables !== want.digit_enables)
            report($sformatf("digit_enables %h, want %h", got.digit_enables,
                             want.digit_enables));
         if (got.last !== want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_kind;
   logic [14:0]           req_number_value;
   logic [1:0]            req_min_digits;
   logic [2:0]            req_point_position;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_bit_valid;
   logic                  rsp_serial_bit;
   logic [3:0]            rsp_digit_enables;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   segment_scoreboard sb = new();
   bit idle_on;
   bit hold_request;

   multiplexed_seven_segment_driver u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_number_value   (req_number_value),
      .req_min_digits     (req_min_digits),
      .req_point_position (req_point_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bit_valid      (rsp_bit_valid),
      .rsp_serial_bit     (rsp_serial_bit),
      .rsp_digit_enables  (rsp_digit_enables),
      .rsp_last           (rsp_last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #5_000_000;
      $display("[multiplexed_seven_segment_driver] ERROR");
      $finish;
   end

   // APB write: setup cycle, then access cycle until pready
   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Offer one word after a random gap; return at the falling edge after acceptance
   task automatic send_item(logic [1:0] kind, logic [14:0] value,
                            logic [1:0] min_digits, logic [2:0] point);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_number_value = value;
      req_min_digits = min_digits;
      req_point_position = point;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_item(kind, value, min_digits, point);
      @(negedge clock);
   endtask

   // Drop valid, wait for every due word, then let a set conversion finish
   task automatic quiesce();
      int waited;
      req_valid = 1'b0;
      waited = 0;
      while (sb.due_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      while (sb.due_words.size() != 0) begin
         sb.report("word still due after drain");
         void'(sb.due_words.pop_front());
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random permutation of the eight segment positions
   function automatic logic [23:0] shuffled_wiring();
      int         order[8];
      int         i;
      int         j;
      int         t;
      logic [23:0] map;
      for (i = 0; i < 8; i++) order[i] = i;
      for (i = 7; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < 8; i++) map[i*3 +: 3] = order[i][2:0];
      return map;
   endfunction

   // Program one register setting per phase, extremes in the early ones
   task automatic config_phase(int phase);
      logic [63:0] lo;
      logic [15:0] hi;
      logic [23:0] wmap;
      logic        inv;
      logic [3:0]  level;
      lo = {$urandom, $urandom};
      hi = 16'($urandom);
      wmap = ($urandom_range(0, 1) != 0) ? shuffled_wiring() : 24'($urandom);
      inv = 1'($urandom_range(0, 1));
      level = 4'($urandom_range(0, 15));
      case (phase)
         1: begin
            lo = 64'h07_7D_6D_66_4F_5B_06_3F;
            hi = 16'h6F_7F;
            wmap = WIRING_RESET;
            inv = 1'b0;
            level = 4'd15;
         end
         2: begin
            lo = '1;
            hi = '1;
            wmap = 24'hFFFFFF;
            inv = 1'b1;
            level = 4'd0;
         end
         3: begin
            // Full brightness right after the longest scan
            wmap = shuffled_wiring();
            inv = 1'b0;
            level = 4'd15;
         end
         4: begin
            lo = '0;
            hi = '0;
            wmap = 24'h000000;
            inv = 1'b0;
         end
         default: begin
         end
      endcase
      write_reg(REG_PAT_LO, lo);
      write_reg(REG_PAT_HI, 64'(hi));
      write_reg(REG_WIRING, 64'(wmap));
      write_reg(REG_INVERT, 64'(inv));
      write_reg(REG_BRIGHTNESS, 64'(level));
   endtask

   // Mostly ticks and sets, with clears and unused kinds mixed in
   task automatic random_item();
      int          pick;
      logic [1:0]  kind;
      logic [14:0] value;
      pick = $urandom_range(0, 99);
      if (pick < 55) kind = KIND_TICK;
      else if (pick < 85) kind = KIND_SET;
      else if (pick < 94) kind = KIND_CLEAR;
      else kind = KIND_UNUSED;
      case ($urandom_range(0, 3))
         0: value = 15'($urandom_range(0, 9));
         1: value = 15'($urandom_range(0, 9999));
         2: value = 15'($urandom_range(0, 32767));
         default: begin
            case ($urandom_range(0, 3))
               0: value = 15'd0;
               1: value = 15'd32767;
               2: value = 15'd9999;
               default: value = 15'd10000;
            endcase
         end
      endcase
      send_item(kind, value, 2'($urandom), 3'($urandom));
   endtask

   // Receiver: random stall before each word, one long hold-off on request
   initial begin
      int stall;
      scan_word_type got;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.bit_valid = rsp_bit_valid;
         got.serial_bit = rsp_serial_bit;
         got.digit_enables = rsp_digit_enables;
         got.last = rsp_last;
         sb.check_word(got);
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin
      int phase;
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_SET;
      req_number_value = '0;
      req_min_digits = '0;
      req_point_position = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults: empty patterns, so only the point shows
      send_item(KIND_SET, 15'd8, 2'd0, 3'd1);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      quiesce();

      // Directed: field extremes, blanking, points, clear and the unused kind
      config_phase(1);
      send_item(KIND_SET, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_SET, 15'd32767, 2'd3, 3'd4);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_SET, 15'd7, 2'd3, 3'd7);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_SET, 15'd1234, 2'd1, 3'd2);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_SET, 15'd9080, 2'd2, 3'd5);
      send_item(KIND_UNUSED, 15'd32767, 2'd3, 3'd7);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_CLEAR, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_SET, 15'd5, 2'd0, 3'd3);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      send_item(KIND_TICK, 15'd0, 2'd0, 3'd0);
      quiesce();

      // Random phases, one register setting each
      for (phase = 2; phase <= 7; phase++) begin
         config_phase(phase);
         idle_on = (phase != 4);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 5 && k == 10) begin
               // Hold the receiver off while ticks keep coming, to fill the block
               hold_request = 1'b1;
               repeat (30) send_item(KIND_TICK, 15'($urandom), 2'($urandom), 3'($urandom));
            end
            if (phase == 5 && k == 20) quiesce();
            random_item();
         end
         quiesce();
      end

      if (sb.errors == 0) begin
         $display("[multiplexed_seven_segment_driver] OK");
      end else begin
         $display("[multiplexed_seven_segment_driver] ERROR");
      end
      $finish;
   end

endmodule
